>>> hw/rtl/chp_pkg.sv
// Shared types, widths and constants for the compass heading core.
// No dependencies; imported by front end, CORDIC cells, back end and top level.
`default_nettype none

package chp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 18;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 18;
    localparam int SCALE_W = 16;
    localparam int DIFF_W  = 19;               // raw - midscale - bias
    localparam int PROD_W  = 35;               // diff * scale, signed
    localparam int AXIS_W  = 34;               // magnitude of the scaled axis
    localparam int PRE_SH  = 24;               // CORDIC input pre-shift
    localparam int CW      = AXIS_W + PRE_SH + 4;
    localparam int ZW      = 25;               // angle accumulator, 1/65536 degree
    localparam int TAB_W   = 22;
    localparam int THETA_W = 23;
    localparam int MAG_W   = 24;
    localparam int DEG_W   = 8;
    localparam int HEAD_W  = 9;

    localparam logic [RAW_W-1:0]   MIDSCALE   = 18'd131072;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 16'd16384;
    localparam logic [THETA_W-1:0] ANG_45     = 23'd2949120;
    localparam logic [THETA_W-1:0] ANG_90     = 23'd5898240;
    localparam logic [MAG_W-1:0]   ANG_180    = 24'd11796480;
    localparam logic [HEAD_W-1:0]  FULL_TURN  = 9'd360;

    localparam logic [CFG_IW-1:0] REG_BIAS_X  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_BIAS_Y  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SCALE_X = 2'd2;
    localparam logic [CFG_IW-1:0] REG_SCALE_Y = 2'd3;

    // arctan(2^-i) in 1/65536 degree, rounded to nearest
    localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
        22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
    };

    // how the first-quadrant angle is chosen at the end of the chain
    typedef enum logic [1:0] {
        ANG_CORDIC = 2'd0,
        ANG_ZERO   = 2'd1,
        ANG_RIGHT  = 2'd2,
        ANG_HALF   = 2'd3
    } ang_sel_t;

    typedef struct packed {
        logic                 vld;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [ZW-1:0] z;
        ang_sel_t             sel;
        logic                 sx_neg;
        logic                 sy_neg;
    } cordic_t;

endpackage

`default_nettype wire

>>> hw/rtl/chp_front.sv
// Front end: configuration registers, axis rebuild, offset removal, scale and
// CORDIC set-up over three stages. Depends on chp_pkg.
`default_nettype none

module chp_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [chp_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [chp_pkg::CFG_DW-1:0]   cfg_data,
    input  wire logic                         in_valid,
    input  wire logic [chp_pkg::BYTE_W-1:0]   x_high_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0]   x_low_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0]   y_high_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0]   y_low_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0]   extra_bits_byte,
    input  wire logic                         adv,
    output chp_pkg::cordic_t                  c_out
);
    import chp_pkg::*;

    logic signed [RAW_W-1:0]   bias_x_reg, bias_y_reg;
    logic        [SCALE_W-1:0] scale_x_reg, scale_y_reg;

    logic                      v1_reg, v2_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic signed [PROD_W-1:0]  sx_reg, sy_reg;
    logic signed [2*DIFF_W-2:0] px, py;
    cordic_t                   c_reg, c_next;

    logic [RAW_W-1:0]    rx, ry;
    logic signed [DIFF_W:0] tx, ty;
    logic [PROD_W-1:0]   nx, ny;
    logic [AXIS_W-1:0]   ax, ay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg  <= '0;
            bias_y_reg  <= '0;
            scale_x_reg <= SCALE_ONE;
            scale_y_reg <= SCALE_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIAS_X:  bias_x_reg  <= cfg_data;
                REG_BIAS_Y:  bias_y_reg  <= cfg_data;
                REG_SCALE_X: scale_x_reg <= cfg_data[SCALE_W-1:0];
                REG_SCALE_Y: scale_y_reg <= cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        rx = {x_high_byte, x_low_byte, extra_bits_byte[7:6]};
        ry = {y_high_byte, y_low_byte, extra_bits_byte[5:4]};
        tx = $signed({2'b00, rx}) - $signed({2'b00, MIDSCALE})
             - {{2{bias_x_reg[RAW_W-1]}}, bias_x_reg};
        ty = $signed({2'b00, ry}) - $signed({2'b00, MIDSCALE})
             - {{2{bias_y_reg[RAW_W-1]}}, bias_y_reg};
        dx_next = tx[DIFF_W-1:0];
        dy_next = ty[DIFF_W-1:0];
    end

    assign px = dx_reg * $signed({1'b0, scale_x_reg});
    assign py = dy_reg * $signed({1'b0, scale_y_reg});

    always_comb
    begin
        nx = -sx_reg;
        ny = -sy_reg;
        ax = sx_reg[PROD_W-1] ? nx[AXIS_W-1:0] : sx_reg[AXIS_W-1:0];
        ay = sy_reg[PROD_W-1] ? ny[AXIS_W-1:0] : sy_reg[AXIS_W-1:0];

        c_next.vld    = v2_reg;
        c_next.a      = $signed({4'b0000, ay, {PRE_SH{1'b0}}});
        c_next.b      = $signed({4'b0000, ax, {PRE_SH{1'b0}}});
        c_next.z      = '0;
        c_next.sx_neg = sx_reg[PROD_W-1];
        c_next.sy_neg = sy_reg[PROD_W-1];
        // X zero wins over Y zero, so both zero also gives heading 0
        if (ax == '0)
            c_next.sel = ANG_ZERO;
        else if (ay == '0)
            c_next.sel = ANG_RIGHT;
        else if (ax == ay)
            c_next.sel = ANG_HALF;
        else
            c_next.sel = ANG_CORDIC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            c_reg.vld <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            c_reg  <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            sx_reg <= px[PROD_W-1:0];
            sy_reg <= py[PROD_W-1:0];
        end
    end

    assign c_out = c_reg;

endmodule

`default_nettype wire

>>> hw/rtl/chp_cell.sv
// One vectoring CORDIC rotation, registered; cells are chained in the top level.
// Depends on chp_pkg for the item type and the arctangent table.
`default_nettype none

module chp_cell #(
    parameter int STEP = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire chp_pkg::cordic_t c_in,
    output chp_pkg::cordic_t      c_out
);
    import chp_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed({3'b000, ATAN_TAB[STEP]});

    cordic_t              c_reg, c_next;
    logic signed [CW-1:0] da, db;

    // arithmetic shift of a signed value rounds toward minus infinity
    assign da = c_in.b >>> STEP;
    assign db = c_in.a >>> STEP;

    always_comb
    begin
        c_next = c_in;
        if (!c_in.b[CW-1])
        begin
            c_next.a = c_in.a + da;
            c_next.b = c_in.b - db;
            c_next.z = c_in.z + ANG;
        end
        else
        begin
            c_next.a = c_in.a - da;
            c_next.b = c_in.b + db;
            c_next.z = c_in.z - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_reg.vld <= 1'b0;
        else if (adv)
            c_reg <= c_next;
    end

    assign c_out = c_reg;

endmodule

`default_nettype wire

>>> hw/rtl/chp_back.sv
// Back end: angle clamp, quadrant fold to whole degrees, two-entry output queue.
// Depends on chp_pkg.
`default_nettype none

module chp_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire chp_pkg::cordic_t            c_in,
    output logic                             adv,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [chp_pkg::HEAD_W-1:0]       heading_deg
);
    import chp_pkg::*;

    logic [THETA_W-1:0] theta;
    logic [MAG_W-1:0]   mag;
    logic [DEG_W-1:0]   deg;
    logic [HEAD_W-1:0]  head;

    logic [1:0]        cnt_reg, cnt_next;
    logic [HEAD_W-1:0] slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic              push, pop;

    always_comb
    begin
        case (c_in.sel)
            ANG_ZERO:  theta = '0;
            ANG_RIGHT: theta = ANG_90;
            ANG_HALF:  theta = ANG_45;
            default:
            begin
                if (c_in.z[ZW-1])
                    theta = '0;
                else if (c_in.z > $signed({2'b00, ANG_90}))
                    theta = ANG_90;
                else
                    theta = c_in.z[THETA_W-1:0];
            end
        endcase

        mag  = c_in.sy_neg ? ANG_180 - {1'b0, theta} : {1'b0, theta};
        deg  = mag[MAG_W-1:MAG_W-DEG_W];
        head = (c_in.sx_neg && deg != '0) ? FULL_TURN - {1'b0, deg} : {1'b0, deg};
    end

    // pipeline moves unless both queue entries are held
    assign adv  = (cnt_reg != 2'd2);
    assign push = adv && c_in.vld;
    assign pop  = (cnt_reg != 2'd0) && out_ready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = head;
                    cnt_next   = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    slot0_next = head;
                else if (push)
                begin
                    slot1_next = head;
                    cnt_next   = 2'd2;
                end
                else if (pop)
                    cnt_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    cnt_next   = 2'd1;
                end
            end
            default: cnt_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid   = (cnt_reg != 2'd0);
    assign heading_deg = slot0_reg;

endmodule

`default_nettype wire

>>> hw/rtl/compass_heading_from_raw_core.sv
// Top level of the compass heading core: front end, CORDIC cell chain, back end.
// Depends on chp_pkg, chp_front, chp_cell and chp_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one magnetometer sample per item:
//   X and Y high and low bytes plus the shared low-bits byte. The output
//   channel out_valid/out_ready returns one heading_deg (0..359) per item,
//   in order.
//   Calibration (bias and scale per axis) is written through cfg_we, cfg_index
//   and cfg_data; the user must write it only while no item is in flight, as
//   the block itself does not enforce this.
//   Throughput: one item per cycle while the output queue has room. Path:
//   three set-up stages, each CORDIC cell, then the output queue register.
//   Stall: the output side holds up to two finished items, so input is still
//   taken while one result waits; the whole pipeline pauses only when both
//   entries are held, and resumes the cycle after one is taken.
//   Reset: rst_n clears every valid flag and the queue, and loads bias 0 and
//   scale 1.0 on both axes. No clearing pass is needed.
`default_nettype none

module compass_heading_from_raw_core #(
    parameter int CORDIC_STEPS = chp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [chp_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [chp_pkg::CFG_DW-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [chp_pkg::BYTE_W-1:0] x_high_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0] x_low_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0] y_high_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0] y_low_byte,
    input  wire logic [chp_pkg::BYTE_W-1:0] extra_bits_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [chp_pkg::HEAD_W-1:0]      heading_deg
);
    import chp_pkg::*;

    cordic_t chain [CORDIC_STEPS+1];
    logic    adv;

    assign in_ready = adv;

    chp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .x_high_byte     (x_high_byte),
        .x_low_byte      (x_low_byte),
        .y_high_byte     (y_high_byte),
        .y_low_byte      (y_low_byte),
        .extra_bits_byte (extra_bits_byte),
        .adv             (adv),
        .c_out           (chain[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        chp_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .c_in  (chain[i]),
            .c_out (chain[i+1])
        );
    end

    chp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .c_in        (chain[CORDIC_STEPS]),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .heading_deg (heading_deg)
    );

endmodule

`default_nettype wire

>>> hw/rtl/chp_checker.sv
// Port-level checks for the compass heading core, bound to the top level.
// No dependencies beyond the top level's port names.
`default_nettype none

module chp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [8:0] heading_deg
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading_deg))
        else $error("output item changed while stalled");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_deg <= 9'd359)
        else $error("heading out of range");

    // with the output queue empty the input side must never block
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output queue");

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output item present straight after reset");

endmodule

bind compass_heading_from_raw_core chp_checker u_chk (.*);

`default_nettype wire
